// ===== hw/rtl/ske_pkg.sv =====
// Package for the sorted keyed entry table: item, result and entry types,
// and the item kind codes.
// No dependencies; used by ske_cell and sorted_keyed_entry_insert_top.
`timescale 1ns / 1ps

package ske_pkg;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Width of the reported entry count and of the read index
  localparam int unsigned CountW = 5;
  localparam int unsigned IndexW = 4;

  // One stored entry: sort key plus colour
  typedef struct packed {
    logic signed [15:0] angle;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
  } entry_t;

  // Input item
  typedef struct packed {
    logic                     kind;
    logic signed [15:0]       angle;
    logic        [7:0]        red;
    logic        [7:0]        green;
    logic        [7:0]        blue;
    logic        [IndexW-1:0] index;
  } in_t;

  // Result item
  typedef struct packed {
    logic                     inserted;
    logic                     dropped;
    logic        [CountW-1:0] entry_count;
    logic                     read_valid;
    logic signed [15:0]       read_angle;
    logic        [7:0]        read_red;
    logic        [7:0]        read_green;
    logic        [7:0]        read_blue;
  } out_t;

endpackage

// ===== hw/rtl/sorted_keyed_entry_insert_top.sv =====
// Top level of the sorted keyed entry table: a row of ske_cell instances,
// the fill counter, the read select and the result register.
// Depends on ske_pkg and ske_cell.
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH (angle, colour) entries sorted by angle, largest
// first. An item is taken when start_i is high and busy_o is low; busy_o is
// never raised, so one item may be given every cycle. Every item gives one
// result on result_o, marked by done_o for a single cycle, on the cycle
// after the item; the receiver must take it then. An insert is compared
// against all cells at once and every cell below the insertion point takes
// its upper neighbor in that same cycle. An insert into a full table is
// refused with dropped set. A read returns the entry at index with the
// count; reads at or past the count return zeros. entry_count is the count
// after the item, modulo 32. Only positions 0 to 15 can be read.
module sorted_keyed_entry_insert_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ske_pkg::in_t  in_i,
  output logic          busy_o,
  output logic          done_o,
  output ske_pkg::out_t result_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RdN  = (TABLE_DEPTH < (1 << ske_pkg::IndexW)) ?
                                 TABLE_DEPTH : (1 << ske_pkg::IndexW);

  logic [CntW-1:0]  count_q, count_d;
  logic             done_q;
  ske_pkg::out_t    result_q, result_d;

  logic             accept;
  logic             is_ins;
  logic             full;
  logic             ins;
  ske_pkg::entry_t  key;
  ske_pkg::entry_t  ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt;
  logic [TABLE_DEPTH-1:0] valid;
  ske_pkg::entry_t  rd_ent;
  logic             rd_hit;
  logic [31:0]      count_ext;

  // No internal stall: busy_o is never raised
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign is_ins = (in_i.kind == ske_pkg::KIND_INSERT);
  assign full   = (count_q == CntW'(TABLE_DEPTH));
  assign ins    = accept && is_ins && !full;

  assign key.angle = in_i.angle;
  assign key.red   = in_i.red;
  assign key.green = in_i.green;
  assign key.blue  = in_i.blue;

  // Row of cells, each fed by its upper neighbor
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign valid[i] = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      ske_cell u_cell (
        .clk_i     (clk_i),
        .ins_i     (ins),
        .valid_i   (valid[i]),
        .key_i     (key),
        .prev_i    (key),
        .prev_gt_i (1'b1),
        .gt_o      (gt[i]),
        .entry_o   (ent[i])
      );
    end else begin : g_body
      ske_cell u_cell (
        .clk_i     (clk_i),
        .ins_i     (ins),
        .valid_i   (valid[i]),
        .key_i     (key),
        .prev_i    (ent[i-1]),
        .prev_gt_i (gt[i-1]),
        .gt_o      (gt[i]),
        .entry_o   (ent[i])
      );
    end
  end

  // Select the addressed cell among the readable positions
  always_comb begin
    rd_ent = '0;
    rd_hit = 1'b0;
    for (int i = 0; i < RdN; i++) begin
      if (in_i.index == ske_pkg::IndexW'(i)) begin
        rd_ent = ent[i];
        rd_hit = valid[i];
      end
    end
  end

  // Advance the count on a stored insert
  assign count_d   = ins ? count_q + CntW'(1) : count_q;
  assign count_ext = 32'(count_d);

  // Build the result
  always_comb begin
    result_d             = '0;
    result_d.entry_count = count_ext[ske_pkg::CountW-1:0];
    if (is_ins) begin
      result_d.inserted = !full;
      result_d.dropped  = full;
    end else if (rd_hit) begin
      result_d.read_valid = 1'b1;
      result_d.read_angle = rd_ent.angle;
      result_d.read_red   = rd_ent.red;
      result_d.read_green = rd_ent.green;
      result_d.read_blue  = rd_ent.blue;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // Every transfer in gives one result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result strobe");

  // A result is never both stored and refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.inserted && result_o.dropped))
    else $error("insert both stored and dropped");

  // A stored insert advances the count by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("count did not advance on insert");

  // Head cells stay in order: a valid cell 1 never holds a larger angle than cell 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TABLE_DEPTH > 1 && valid[1]) |-> !(ent[1].angle > ent[0].angle))
    else $error("head cells out of order");

endmodule

// ===== hw/rtl/ske_cell.sv =====
// One table cell: holds an entry, compares it with the incoming key and
// on an insert keeps, loads the new entry, or takes its upper neighbor.
// Depends on ske_pkg.
`timescale 1ns / 1ps

module ske_cell (
  input  logic            clk_i,
  input  logic            ins_i,      // insert applied this cycle
  input  logic            valid_i,    // cell lies below the fill count
  input  ske_pkg::entry_t key_i,      // entry being inserted
  input  ske_pkg::entry_t prev_i,     // entry of the upper neighbor
  input  logic            prev_gt_i,  // upper neighbor stays put (tied high on cell 0)
  output logic            gt_o,       // stored angle strictly above the key
  output ske_pkg::entry_t entry_o
);

  ske_pkg::entry_t entry_q, entry_d;

  // Compare stored key against the new one; empty cells never win
  assign gt_o = valid_i && (entry_q.angle > key_i.angle);

  // New entry lands where the neighbor above stays and this cell moves
  assign entry_d = prev_gt_i ? key_i : prev_i;

  // Hold unless an insert moves this cell
  always_ff @(posedge clk_i) begin
    if (ins_i && !gt_o) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
